// ----- rtl/jptd_pkg.sv -----
// shared types, character codes and helpers for the json pointer token decoder
`timescale 1ns / 1ps

package jptd_pkg;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_AFTER_HASH = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_NO_HASH = 3'd1,
    ST_NO_SLASH = 3'd2,
    ST_BAD_TILDE = 3'd3,
    ST_BAD_PCT = 3'd4
  } status_t;

  // one input word held in the input register
  typedef struct packed {
    logic       vld;
    logic [7:0] byte_val;
    logic       eos;
  } step_t;

  // one result word as it leaves the decode logic
  typedef struct packed {
    logic       vld;
    logic [7:0] byte_val;
    logic       byte_valid;
    logic       segment_end;
    logic       done_res;
    status_t    status;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t h;
    h.ok = 1'b1;
    h.nib = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.nib = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.nib = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.nib = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// ----- rtl/jptd_in_stage.sv -----
// input register stage of the json pointer token decoder
`timescale 1ns / 1ps

module jptd_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_end_of_string,
  input  logic              advance,
  output jptd_pkg::step_t   step
);

  logic       vld_r, vld_nxt;
  logic [7:0] byte_r;
  logic       eos_r;

  // the held word leaves when the result side moves
  assign in_ready = !vld_r || advance;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
      eos_r  <= in_end_of_string;
    end
  end

  assign step.vld      = vld_r;
  assign step.byte_val = byte_r;
  assign step.eos      = eos_r;

endmodule

// ----- rtl/jptd_core.sv -----
// parse state and per-word decode logic of the json pointer token decoder
`timescale 1ns / 1ps

module jptd_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fragment_mode,
  input  logic             fire,
  input  jptd_pkg::step_t  step,
  output jptd_pkg::res_t   res
);

  jptd_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]       hexp_r, hexp_nxt;
  logic [3:0]       hi_r, hi_nxt;
  logic             tilde_r, tilde_nxt;
  logic             err_r, err_nxt;

  jptd_pkg::hex_t   hv;
  logic             feed;
  logic [7:0]       c;
  logic [7:0]       b;

  assign b  = step.byte_val;
  assign hv = jptd_pkg::hex_value(b);

  // decoded byte headed for the pointer stage
  always_comb begin
    feed = 1'b0;
    c    = b;
    if (!step.eos && !err_r) begin
      if (hexp_r != 2'd0) begin
        if (hv.ok && hexp_r == 2'd1) begin
          feed = 1'b1;
          c    = {hi_r, hv.nib};
        end
      end else if (phase_r != jptd_pkg::PH_FIRST) begin
        if (fragment_mode && b == jptd_pkg::CH_PLUS) begin
          feed = 1'b1;
          c    = jptd_pkg::CH_SPACE;
        end else if (!(fragment_mode && b == jptd_pkg::CH_PCT)) begin
          feed = 1'b1;
        end
      end
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    hexp_nxt  = hexp_r;
    hi_nxt    = hi_r;
    tilde_nxt = tilde_r;
    err_nxt   = err_r;
    if (step.eos) begin
      phase_nxt = jptd_pkg::PH_FIRST;
      hexp_nxt  = 2'd0;
      hi_nxt    = 4'd0;
      tilde_nxt = 1'b0;
      err_nxt   = 1'b0;
    end else if (!err_r) begin
      if (hexp_r != 2'd0) begin
        if (!hv.ok) begin
          err_nxt = 1'b1;
        end else if (hexp_r == 2'd2) begin
          hi_nxt   = hv.nib;
          hexp_nxt = 2'd1;
        end else begin
          hexp_nxt = 2'd0;
        end
      end else if (phase_r == jptd_pkg::PH_FIRST) begin
        if (fragment_mode) begin
          if (b == jptd_pkg::CH_HASH) phase_nxt = jptd_pkg::PH_AFTER_HASH;
          else err_nxt = 1'b1;
        end else begin
          if (b == jptd_pkg::CH_SLASH) phase_nxt = jptd_pkg::PH_BODY;
          else err_nxt = 1'b1;
        end
      end else if (fragment_mode && b == jptd_pkg::CH_PCT) begin
        hexp_nxt = 2'd2;
      end
      // pointer stage
      if (feed) begin
        if (phase_r == jptd_pkg::PH_AFTER_HASH) begin
          if (c == jptd_pkg::CH_SLASH) phase_nxt = jptd_pkg::PH_BODY;
          else err_nxt = 1'b1;
        end else if (tilde_r) begin
          tilde_nxt = 1'b0;
          if (c != jptd_pkg::CH_ZERO && c != jptd_pkg::CH_ONE) err_nxt = 1'b1;
        end else if (c == jptd_pkg::CH_TILDE) begin
          tilde_nxt = 1'b1;
        end
      end
    end
  end

  // result word
  always_comb begin
    res.vld         = 1'b0;
    res.byte_val    = 8'd0;
    res.byte_valid  = 1'b0;
    res.segment_end = 1'b0;
    res.done_res    = 1'b0;
    res.status      = jptd_pkg::ST_OK;
    if (step.eos) begin
      if (!err_r) begin
        res.vld      = 1'b1;
        res.done_res = 1'b1;
        if (hexp_r != 2'd0) begin
          res.status = jptd_pkg::ST_BAD_PCT;
        end else if (phase_r == jptd_pkg::PH_FIRST) begin
          if (fragment_mode) res.status = jptd_pkg::ST_NO_HASH;
        end else if (phase_r == jptd_pkg::PH_AFTER_HASH) begin
          res.status = jptd_pkg::ST_OK;
        end else if (tilde_r) begin
          res.status = jptd_pkg::ST_BAD_TILDE;
        end else begin
          res.segment_end = 1'b1;
        end
      end
    end else if (err_r) begin
      res.vld = 1'b0;
    end else if (hexp_r != 2'd0 && !hv.ok) begin
      res.vld      = 1'b1;
      res.done_res = 1'b1;
      res.status   = jptd_pkg::ST_BAD_PCT;
    end else if (hexp_r == 2'd0 && phase_r == jptd_pkg::PH_FIRST) begin
      if (fragment_mode && b != jptd_pkg::CH_HASH) begin
        res.vld      = 1'b1;
        res.done_res = 1'b1;
        res.status   = jptd_pkg::ST_NO_HASH;
      end else if (!fragment_mode && b != jptd_pkg::CH_SLASH) begin
        res.vld      = 1'b1;
        res.done_res = 1'b1;
        res.status   = jptd_pkg::ST_NO_SLASH;
      end
    end else if (feed) begin
      if (phase_r == jptd_pkg::PH_AFTER_HASH) begin
        if (c != jptd_pkg::CH_SLASH) begin
          res.vld      = 1'b1;
          res.done_res = 1'b1;
          res.status   = jptd_pkg::ST_NO_SLASH;
        end
      end else if (tilde_r) begin
        res.vld = 1'b1;
        if (c == jptd_pkg::CH_ZERO) begin
          res.byte_val   = jptd_pkg::CH_TILDE;
          res.byte_valid = 1'b1;
        end else if (c == jptd_pkg::CH_ONE) begin
          res.byte_val   = jptd_pkg::CH_SLASH;
          res.byte_valid = 1'b1;
        end else begin
          res.done_res = 1'b1;
          res.status   = jptd_pkg::ST_BAD_TILDE;
        end
      end else if (c == jptd_pkg::CH_SLASH) begin
        res.vld         = 1'b1;
        res.segment_end = 1'b1;
      end else if (c != jptd_pkg::CH_TILDE) begin
        res.vld        = 1'b1;
        res.byte_val   = c;
        res.byte_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= jptd_pkg::PH_FIRST;
      hexp_r  <= 2'd0;
      hi_r    <= 4'd0;
      tilde_r <= 1'b0;
      err_r   <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      hexp_r  <= hexp_nxt;
      hi_r    <= hi_nxt;
      tilde_r <= tilde_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

// ----- rtl/json_pointer_token_decoder_top.sv -----
// top level of the json pointer token decoder
`timescale 1ns / 1ps

// channel  direction  handshake            payload
// in       input      in_valid/in_ready    in_byte, in_end_of_string
// out      output     out_valid/out_ready  out_byte, out_byte_valid, out_segment_end,
//                                          out_done_res, out_status
// cfg      input      cfg_valid/cfg_ready  cfg_fragment_mode
//
// one word per cycle sustained while out_ready is high; a word accepted goes from the
// input register through the decode logic into the output register
// a word that produces no result only updates the parse state
// rst_n is synchronous, active low; it clears the parse state, mode and valid flags
// a stalled result holds in the output register while the input register still
// takes one more word; in_ready drops only when both are full

module json_pointer_token_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_string,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_segment_end,
  output logic       out_done_res,
  output logic [2:0] out_status,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_fragment_mode
);

  jptd_pkg::step_t step;
  jptd_pkg::res_t  res;
  logic            advance;
  logic            fire;

  logic            frag_r, frag_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_byte_r;
  logic            out_bv_r;
  logic            out_seg_r;
  logic            out_done_r;
  logic [2:0]      out_status_r;

  // result register is free or being drained this cycle
  assign advance = !out_valid_r || out_ready;
  // held input word goes through the decode logic
  assign fire    = step.vld && advance;

  // config register, always ready
  assign cfg_ready = 1'b1;
  always_comb begin
    frag_nxt = frag_r;
    if (cfg_valid) frag_nxt = cfg_fragment_mode;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frag_r <= 1'b0;
    end else begin
      frag_r <= frag_nxt;
    end
  end

  jptd_in_stage u_in (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .advance          (advance),
    .step             (step)
  );

  jptd_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .fragment_mode (frag_r),
    .fire          (fire),
    .step          (step),
    .res           (res)
  );

  // result register: load on every advance, valid only when the word made a result
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) out_valid_nxt = fire && res.vld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r   <= res.byte_val;
      out_bv_r     <= res.byte_valid;
      out_seg_r    <= res.segment_end;
      out_done_r   <= res.done_res;
      out_status_r <= res.status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_byte_valid  = out_bv_r;
  assign out_segment_end = out_seg_r;
  assign out_done_res    = out_done_r;
  assign out_status      = out_status_r;

endmodule

// ----- rtl/jptd_checker.sv -----
// port-level checker for the json pointer token decoder and its bind
`timescale 1ns / 1ps

module jptd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_byte_valid,
  input logic       out_segment_end,
  input logic       out_done_res,
  input logic [2:0] out_status
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_byte_valid) && $stable(out_segment_end) &&
      $stable(out_done_res) && $stable(out_status))
    else $error("result word changed while stalled");

  // a character word never closes a token or the string
  a_byte_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_valid |-> !out_segment_end && !out_done_res &&
      out_status == jptd_pkg::ST_OK)
    else $error("character word carries other flags");

  // an error word is final and carries nothing else
  a_err_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != jptd_pkg::ST_OK |-> out_done_res &&
      !out_byte_valid && !out_segment_end)
    else $error("error word malformed");

  // byte field is zero without a character
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_byte == 8'd0)
    else $error("stray byte value");

  // input stalls only behind a held result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

endmodule

bind json_pointer_token_decoder_top jptd_checker u_jptd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_byte        (out_byte),
  .out_byte_valid  (out_byte_valid),
  .out_segment_end (out_segment_end),
  .out_done_res    (out_done_res),
  .out_status      (out_status)
);
